>>> rtl/asrs_pkg.sv
package asrs_pkg;

  // action codes on the input channel
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;

  // register map selected by command bits 5..3
  localparam logic [2:0] REG_STATUS    = 3'd0;
  localparam logic [2:0] REG_MODE      = 3'd1;
  localparam logic [2:0] REG_CONFIG    = 3'd2;
  localparam logic [2:0] REG_DATA      = 3'd3;
  localparam logic [2:0] REG_ID        = 3'd4;
  localparam logic [2:0] REG_IO        = 3'd5;
  localparam logic [2:0] REG_OFFSET    = 3'd6;
  localparam logic [2:0] REG_FULLSCALE = 3'd7;

  // configuration port indexes
  localparam int          CFG_IDX_W  = 1;
  localparam int          CFG_DATA_W = 16;
  localparam logic [0:0]  CFG_PERIOD = 1'b0;
  localparam logic [0:0]  CFG_DEVID  = 1'b1;

  // reset values
  localparam logic [15:0] PERIOD_RST    = 16'd50;
  localparam logic [7:0]  DEVID_RST     = 8'h4B;
  localparam logic [6:0]  STATUS_LOW    = 7'h08;   // status bits 6..0, never change
  localparam logic [15:0] MODE_RST      = 16'h000A;
  localparam logic [15:0] CONFIG_RST    = 16'h0710;
  localparam logic [7:0]  IO_RST        = 8'h00;
  localparam logic [23:0] OFFSET_RST    = 24'h800000;
  localparam logic [23:0] FULLSCALE_RST = 24'h5A5A5A;
  localparam logic [23:0] SAMPLE_RST    = 24'h123456;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    K_BYTE  = 4'b0001,
    K_TICK  = 4'b0010,
    K_ABORT = 4'b0100,
    K_NOP   = 4'b1000
  } kind_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] sample;
    logic        cmd_ok;     // bit 7 clear
    logic        cmd_read;
    logic [2:0]  cmd_sel;
    logic        cmd_cont;
    logic [1:0]  cmd_len;    // bytes to move, 0 for a write with no payload
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> rtl/asrs_front.sv
module asrs_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_action,
  input  logic [7:0]      in_spi_in_byte,
  input  logic [23:0]     in_conversion_data,
  input  asrs_pkg::q_stat_t q_stat,
  output logic            push,
  output asrs_pkg::item_t push_item
);
  import asrs_pkg::*;

  function automatic logic [1:0] read_len(input logic [2:0] sel);
    logic [1:0] n;
    unique case (sel) inside
      REG_MODE, REG_CONFIG:                   n = 2'd2;
      REG_DATA, REG_OFFSET, REG_FULLSCALE:    n = 2'd3;
      default:                                n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] write_len(input logic [2:0] sel);
    logic [1:0] n;
    unique case (sel) inside
      REG_MODE, REG_CONFIG:       n = 2'd2;
      REG_IO:                     n = 2'd1;
      REG_OFFSET, REG_FULLSCALE:  n = 2'd3;
      default:                    n = 2'd0;
    endcase
    return n;
  endfunction

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.data     = in_spi_in_byte;
    push_item.sample   = in_conversion_data;
    push_item.cmd_ok   = !in_spi_in_byte[7];
    push_item.cmd_read = in_spi_in_byte[6];
    push_item.cmd_sel  = in_spi_in_byte[5:3];
    push_item.cmd_cont = in_spi_in_byte[2];
    push_item.cmd_len  = in_spi_in_byte[6] ? read_len(in_spi_in_byte[5:3])
                                           : write_len(in_spi_in_byte[5:3]);
    unique case (in_action)
      ACT_BYTE:  push_item.kind = K_BYTE;
      ACT_TICK:  push_item.kind = K_TICK;
      ACT_ABORT: push_item.kind = K_ABORT;
      default:   push_item.kind = K_NOP;
    endcase
  end

endmodule

>>> rtl/asrs_queue.sv
module asrs_queue #(
  parameter int DEPTH = asrs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  asrs_pkg::item_t            push_item,
  input  logic                       pop,
  output asrs_pkg::item_t            pop_item,
  output asrs_pkg::q_stat_t          q_stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import asrs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign count        = cnt_r;

endmodule

>>> rtl/asrs_back.sv
module asrs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asrs_pkg::item_t                pop_item,
  input  asrs_pkg::q_stat_t              q_stat,
  output logic                           pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [asrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asrs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_miso_byte,
  output logic                           out_ready_n,
  output logic                           out_transfer_last,
  output logic [15:0]                    out_mode_value,
  output logic [15:0]                    out_config_value,
  output logic [7:0]                     out_io_value
);
  import asrs_pkg::*;

  // left-align a register value in the shifter, ones below it
  function automatic logic [23:0] align(input logic [23:0] v, input logic [1:0] len);
    logic [23:0] s;
    case (len)
      2'd1:    s = {v[7:0], 16'hFFFF};
      2'd2:    s = {v[15:0], 8'hFF};
      default: s = v;
    endcase
    return s;
  endfunction

  logic [15:0] period_r;
  logic [7:0]  devid_r;

  logic        await_r,  await_nxt;
  logic        read_r,   read_nxt;
  logic [2:0]  sel_r,    sel_nxt;
  logic        cont_r,   cont_nxt;
  logic [1:0]  total_r,  total_nxt;
  logic [1:0]  idx_r,    idx_nxt;
  logic [23:0] shout_r,  shout_nxt;
  logic [23:0] shin_r,   shin_nxt;
  logic [15:0] mode_r,   mode_nxt;
  logic [15:0] conf_r,   conf_nxt;
  logic [7:0]  io_r,     io_nxt;
  logic [23:0] offs_r,   offs_nxt;
  logic [23:0] fscale_r, fscale_nxt;
  logic [23:0] sample_r, sample_nxt;
  logic        dr_r,     dr_nxt;
  logic [15:0] tick_r,   tick_nxt;
  logic        ov_r,     ov_nxt;

  logic [7:0]  omiso_r;
  logic        ordy_n_r, olast_r;
  logic [15:0] omode_r,  oconf_r;
  logic [7:0]  oio_r;

  logic [7:0]  miso;
  logic        last;
  logic [1:0]  idx_inc;
  logic [15:0] tick_inc;
  logic [23:0] rd_val;

  assign pop       = !q_stat.empty && (!ov_r || out_ready);
  assign cfg_ready = 1'b1;

  // readback mux for a read command
  always_comb begin
    unique case (pop_item.cmd_sel)
      REG_STATUS:    rd_val = {16'h0, !dr_r, STATUS_LOW};
      REG_MODE:      rd_val = {8'h0, mode_r};
      REG_CONFIG:    rd_val = {8'h0, conf_r};
      REG_DATA:      rd_val = sample_r;
      REG_ID:        rd_val = {16'h0, devid_r};
      REG_IO:        rd_val = {16'h0, io_r};
      REG_OFFSET:    rd_val = offs_r;
      default:       rd_val = fscale_r;
    endcase
  end

  always_comb begin
    await_nxt  = await_r;
    read_nxt   = read_r;
    sel_nxt    = sel_r;
    cont_nxt   = cont_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    shout_nxt  = shout_r;
    shin_nxt   = shin_r;
    mode_nxt   = mode_r;
    conf_nxt   = conf_r;
    io_nxt     = io_r;
    offs_nxt   = offs_r;
    fscale_nxt = fscale_r;
    sample_nxt = sample_r;
    dr_nxt     = dr_r;
    tick_nxt   = tick_r;
    miso       = 8'hFF;
    last       = 1'b0;
    idx_inc    = idx_r + 2'd1;
    tick_inc   = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;

    if (pop) begin
      unique case (pop_item.kind)
        K_BYTE: begin
          if (await_r) begin
            if (pop_item.cmd_ok) begin
              read_nxt  = pop_item.cmd_read;
              sel_nxt   = pop_item.cmd_sel;
              cont_nxt  = pop_item.cmd_cont;
              shin_nxt  = '0;
              idx_nxt   = '0;
              total_nxt = pop_item.cmd_len;
              if (pop_item.cmd_read) begin
                shout_nxt = align(rd_val, pop_item.cmd_len);
                if (pop_item.cmd_sel == REG_DATA) begin
                  dr_nxt = 1'b0;
                end
                await_nxt = 1'b0;
              end else begin
                await_nxt = (pop_item.cmd_len == 2'd0);
              end
            end
          end else begin
            if (read_r) begin
              miso      = shout_r[23:16];
              shout_nxt = {shout_r[15:0], 8'hFF};
            end else begin
              shin_nxt  = {shin_r[15:0], pop_item.data};
            end
            idx_nxt = idx_inc;
            if (idx_inc >= total_r) begin
              last = 1'b1;
              if (!read_r) begin
                case (sel_r)
                  REG_MODE:      begin mode_nxt = shin_nxt[15:0]; dr_nxt = 1'b0; end
                  REG_CONFIG:    begin conf_nxt = shin_nxt[15:0]; dr_nxt = 1'b0; end
                  REG_IO:        io_nxt = shin_nxt[7:0];
                  REG_OFFSET:    offs_nxt = shin_nxt;
                  REG_FULLSCALE: fscale_nxt = shin_nxt;
                  default:       ;
                endcase
              end
              if (cont_r && read_r && sel_r == REG_DATA) begin
                // continuous read: reload the sample and go again
                shout_nxt = sample_r;
                dr_nxt    = 1'b0;
                total_nxt = 2'd3;
                idx_nxt   = '0;
              end else begin
                await_nxt = 1'b1;
                total_nxt = '0;
                idx_nxt   = '0;
              end
            end
          end
        end
        K_TICK: begin
          if (tick_inc >= period_r) begin
            tick_nxt   = '0;
            sample_nxt = pop_item.sample;
            dr_nxt     = 1'b1;
          end else begin
            tick_nxt   = tick_inc;
          end
        end
        K_ABORT: begin
          await_nxt = 1'b1;
          total_nxt = '0;
          idx_nxt   = '0;
          shout_nxt = '1;
        end
        default: ;
      endcase
    end

    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      devid_r  <= DEVID_RST;
      await_r  <= 1'b1;
      read_r   <= 1'b0;
      sel_r    <= REG_STATUS;
      cont_r   <= 1'b0;
      total_r  <= '0;
      idx_r    <= '0;
      shout_r  <= '1;
      shin_r   <= '0;
      mode_r   <= MODE_RST;
      conf_r   <= CONFIG_RST;
      io_r     <= IO_RST;
      offs_r   <= OFFSET_RST;
      fscale_r <= FULLSCALE_RST;
      sample_r <= SAMPLE_RST;
      dr_r     <= 1'b0;
      tick_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PERIOD: period_r <= cfg_data;
          CFG_DEVID:  devid_r  <= cfg_data[7:0];
          default:    ;
        endcase
      end
      await_r  <= await_nxt;
      read_r   <= read_nxt;
      sel_r    <= sel_nxt;
      cont_r   <= cont_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
      shout_r  <= shout_nxt;
      shin_r   <= shin_nxt;
      mode_r   <= mode_nxt;
      conf_r   <= conf_nxt;
      io_r     <= io_nxt;
      offs_r   <= offs_nxt;
      fscale_r <= fscale_nxt;
      sample_r <= sample_nxt;
      dr_r     <= dr_nxt;
      tick_r   <= tick_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // result register, loaded on every executed word
  always_ff @(posedge clk) begin
    if (pop) begin
      omiso_r  <= miso;
      ordy_n_r <= !dr_nxt;
      olast_r  <= last;
      omode_r  <= mode_nxt;
      oconf_r  <= conf_nxt;
      oio_r    <= io_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_miso_byte     = omiso_r;
  assign out_ready_n       = ordy_n_r;
  assign out_transfer_last = olast_r;
  assign out_mode_value    = omode_r;
  assign out_config_value  = oconf_r;
  assign out_io_value      = oio_r;

endmodule

>>> rtl/adc_spi_register_slave.sv
// Channel  Handshake            Payload
// in_      in_valid/in_ready    in_action[1:0] in_spi_in_byte[7:0] in_conversion_data[23:0]
// out_     out_valid/out_ready  out_miso_byte[7:0] out_ready_n out_transfer_last
//                               out_mode_value[15:0] out_config_value[15:0] out_io_value[7:0]
// cfg_     cfg_valid/cfg_ready  cfg_index[0:0] cfg_data[15:0]
//
// One word per cycle sustained while out_ready stays high. A word is queued when
// accepted and executed into the result register once it heads the queue and no
// held result is waiting. Rate is set by the back end, which executes one queued
// word per cycle unless a held result waits. rst_n is synchronous, active low;
// control and register-file state return to defaults, queue storage and result
// data do not. A stall on out_ready holds the result register; the queue absorbs
// up to DEPTH words before in_ready drops.
module adc_spi_register_slave #(
  parameter int DEPTH = asrs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [7:0]                      in_spi_in_byte,
  input  logic [23:0]                     in_conversion_data,
  // results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_miso_byte,
  output logic                            out_ready_n,
  output logic                            out_transfer_last,
  output logic [15:0]                     out_mode_value,
  output logic [15:0]                     out_config_value,
  output logic [7:0]                      out_io_value,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [asrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import asrs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          push, pop;
  item_t         push_item, pop_item;
  q_stat_t       q_stat;
  logic [CW-1:0] q_count;

  // front: classify action and decode command fields
  asrs_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_spi_in_byte     (in_spi_in_byte),
    .in_conversion_data (in_conversion_data),
    .q_stat             (q_stat),
    .push               (push),
    .push_item          (push_item)
  );

  // short queue decoupling front and back
  asrs_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat),
    .count     (q_count)
  );

  // back: register file, shifters, conversion timer, result register
  asrs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_item          (pop_item),
    .q_stat            (q_stat),
    .pop               (pop),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_miso_byte     (out_miso_byte),
    .out_ready_n       (out_ready_n),
    .out_transfer_last (out_transfer_last),
    .out_mode_value    (out_mode_value),
    .out_config_value  (out_config_value),
    .out_io_value      (out_io_value)
  );

  // queue occupancy never passes its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(DEPTH))
    else $error("queue overflow");

  // back never executes a word while a held result is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !pop)
    else $error("result overwritten under stall");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a pushed word with an empty queue and free output is executed next cycle
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_stat.empty && (!out_valid || out_ready)) |=> pop)
    else $error("queued word not executed");

endmodule

>>> dv/adc_spi_register_slave_tb.sv
`timescale 1ns / 100ps

module adc_spi_register_slave_tb;
  import asrs_pkg::*;

  // action code 3 has no package name; the slave treats it as a no-op word
  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam logic [7:0] NOT_READY   = 8'h80;   // status bit 7
  localparam logic [7:0] IDLE_MISO   = 8'hFF;   // MISO level outside read data
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_CYCLES = 6;      // margin for the pipeline to empty
  localparam int         IDLE_PCT    = 7;

  // one result word as seen on the out_ channel
  typedef struct packed {
    logic [7:0]  miso;
    logic        rdy_n;
    logic        last;
    logic [15:0] mode;
    logic [15:0] cfg;
    logic [7:0]  io;
  } slave_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_action;
  logic [7:0]            in_spi_in_byte;
  logic [23:0]           in_conversion_data;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [7:0]            out_miso_byte;
  logic                  out_ready_n;
  logic                  out_transfer_last;
  logic [15:0]           out_mode_value;
  logic [15:0]           out_config_value;
  logic [7:0]            out_io_value;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit                    steady = 1'b0;   // suppresses idling on both sides
  int                    mismatches = 0;
  int                    cycles = 0;
  slave_word_t           words_due[$];    // predicted results, oldest first

  adc_spi_register_slave DUT (.*);

  always #1 clk = ~clk;

  // ------------------------------------------------------------------
  // Predictor state: a private copy of every slave register and the
  // two settings, advanced once per accepted input word.
  // ------------------------------------------------------------------
  logic [15:0] adc_period    = PERIOD_RST;
  logic [7:0]  adc_devid     = DEVID_RST;
  logic        adc_await     = 1'b1;
  logic        adc_rd        = 1'b0;
  logic [2:0]  adc_sel       = REG_STATUS;
  logic        adc_cont      = 1'b0;
  logic [1:0]  adc_len       = 2'd0;
  logic [1:0]  adc_idx       = 2'd0;
  logic [23:0] adc_sout      = 24'hFFFFFF;
  logic [23:0] adc_sin       = 24'h0;
  logic [7:0]  adc_status    = {1'b1, STATUS_LOW};
  logic [15:0] adc_mode      = MODE_RST;
  logic [15:0] adc_cfgr      = CONFIG_RST;
  logic [7:0]  adc_io        = IO_RST;
  logic [23:0] adc_offset    = OFFSET_RST;
  logic [23:0] adc_fullscale = FULLSCALE_RST;
  logic [23:0] adc_sample    = SAMPLE_RST;
  logic        adc_drdy      = 1'b0;
  logic [15:0] adc_ticks     = 16'd0;

  function automatic void adc_mark_busy();
    adc_status = adc_status | NOT_READY;
    adc_drdy   = 1'b0;
  endfunction

  // left-align the selected register in the shifter, pad with ones
  function automatic void adc_load_read();
    logic [23:0] v;
    case (adc_sel)
      REG_STATUS:    begin v = {16'h0, adc_status}; adc_len = 2'd1; end
      REG_MODE:      begin v = {8'h0, adc_mode};    adc_len = 2'd2; end
      REG_CONFIG:    begin v = {8'h0, adc_cfgr};    adc_len = 2'd2; end
      REG_DATA:      begin v = adc_sample;          adc_len = 2'd3; adc_mark_busy(); end
      REG_ID:        begin v = {16'h0, adc_devid};  adc_len = 2'd1; end
      REG_IO:        begin v = {16'h0, adc_io};     adc_len = 2'd1; end
      REG_OFFSET:    begin v = adc_offset;          adc_len = 2'd3; end
      default:       begin v = adc_fullscale;       adc_len = 2'd3; end
    endcase
    case (adc_len)
      2'd1:    adc_sout = {v[7:0], 16'hFFFF};
      2'd2:    adc_sout = {v[15:0], 8'hFF};
      default: adc_sout = v;
    endcase
    adc_idx = 2'd0;
  endfunction

  // advance the slave by one word and queue the result it must produce
  function automatic void adc_step(input logic [1:0] act, input logic [7:0] b,
                                   input logic [23:0] smp);
    slave_word_t w;
    w.miso = IDLE_MISO;
    w.last = 1'b0;
    case (act)
      ACT_BYTE: begin
        if (adc_await) begin
          // bit 7 set: not a command, stay in command wait
          if (!b[7]) begin
            adc_rd   = b[6];
            adc_sel  = b[5:3];
            adc_cont = b[2];
            adc_sin  = 24'h0;
            adc_idx  = 2'd0;
            if (adc_rd) begin
              adc_load_read();
              adc_await = 1'b0;
            end else begin
              case (adc_sel) inside
                REG_MODE, REG_CONFIG:      adc_len = 2'd2;
                REG_IO:                    adc_len = 2'd1;
                REG_OFFSET, REG_FULLSCALE: adc_len = 2'd3;
                default:                   adc_len = 2'd0;  // nothing to receive
              endcase
              adc_await = (adc_len == 2'd0);
            end
          end
        end else begin
          if (adc_rd) begin
            w.miso   = adc_sout[23:16];
            adc_sout = {adc_sout[15:0], 8'hFF};
          end else begin
            adc_sin = {adc_sin[15:0], b};
          end
          adc_idx = adc_idx + 2'd1;
          if (adc_idx >= adc_len) begin
            w.last = 1'b1;
            if (!adc_rd) begin
              case (adc_sel)
                REG_MODE:      begin adc_mode = adc_sin[15:0]; adc_mark_busy(); end
                REG_CONFIG:    begin adc_cfgr = adc_sin[15:0]; adc_mark_busy(); end
                REG_IO:        adc_io = adc_sin[7:0];
                REG_OFFSET:    adc_offset = adc_sin;
                REG_FULLSCALE: adc_fullscale = adc_sin;
                default: ;
              endcase
            end
            // continuous data read reloads and keeps shifting
            if (adc_cont && adc_rd && adc_sel == REG_DATA) begin
              adc_load_read();
            end else begin
              adc_await = 1'b1;
              adc_len   = 2'd0;
              adc_idx   = 2'd0;
            end
          end
        end
      end
      ACT_TICK: begin
        if (adc_ticks != 16'hFFFF) adc_ticks = adc_ticks + 16'd1;
        if (adc_ticks >= adc_period) begin
          adc_ticks  = 16'd0;
          adc_sample = smp;
          adc_status = adc_status & ~NOT_READY;
          adc_drdy   = 1'b1;
        end
      end
      ACT_ABORT: begin
        adc_await = 1'b1;
        adc_len   = 2'd0;
        adc_idx   = 2'd0;
        adc_sout  = 24'hFFFFFF;
      end
      default: ;  // spare code: no state change
    endcase
    w.rdy_n = ~adc_drdy;
    w.mode  = adc_mode;
    w.cfg   = adc_cfgr;
    w.io    = adc_io;
    words_due.push_back(w);
  endfunction

  // ------------------------------------------------------------------
  // Drivers. All tasks start and end right after a falling edge.
  // ------------------------------------------------------------------

  // sends one word; valid drops at the next falling edge unless the
  // following call raises it again in the same step
  task automatic send_word(input logic [1:0] act, input logic [7:0] b,
                           input logic [23:0] smp);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) @(negedge clk);
    in_valid           = 1'b1;
    in_action          = act;
    in_spi_in_byte     = b;
    in_conversion_data = smp;
    do @(posedge clk); while (!in_ready);
    adc_step(act, b, smp);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // all results in, then let the pipeline empty
  task automatic wait_quiet();
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PERIOD) adc_period = val;
    else adc_devid = val[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] cmd_byte(input logic rd, input logic [2:0] sel,
                                          input logic cont);
    return {1'b0, rd, sel, cont, 2'b00};
  endfunction

  // receiver side stalls independently of the sender
  always @(negedge clk) out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // ------------------------------------------------------------------
  // Result checking against the oldest predicted word
  // ------------------------------------------------------------------
  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    slave_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $display("%0t ns: result word with none expected, miso %0h", $time, out_miso_byte);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        check_field("miso_byte", 24'(want.miso), 24'(out_miso_byte));
        check_field("ready_n", 24'(want.rdy_n), 24'(out_ready_n));
        check_field("transfer_last", 24'(want.last), 24'(out_transfer_last));
        check_field("mode_value", 24'(want.mode), 24'(out_mode_value));
        check_field("config_value", 24'(want.cfg), 24'(out_config_value));
        check_field("io_value", 24'(want.io), 24'(out_io_value));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // reset values read back, then 1- and 2-byte writes of all ones
  task automatic test_register_access();
    send_word(ACT_BYTE, cmd_byte(1'b1, REG_STATUS, 1'b0), 24'h000000);
    send_word(ACT_BYTE, 8'h00, 24'hFFFFFF);
    send_word(ACT_BYTE, cmd_byte(1'b1, REG_ID, 1'b0), 24'h000000);
    send_word(ACT_BYTE, 8'hFF, 24'h000000);
    send_word(ACT_BYTE, cmd_byte(1'b0, REG_IO, 1'b0), 24'h000000);
    send_word(ACT_BYTE, 8'hFF, 24'h000000);
    send_word(ACT_BYTE, cmd_byte(1'b1, REG_IO, 1'b0), 24'h000000);
    send_word(ACT_BYTE, 8'h00, 24'h000000);
    send_word(ACT_BYTE, cmd_byte(1'b0, REG_MODE, 1'b0), 24'h000000);
    send_word(ACT_BYTE, 8'hFF, 24'h000000);
    send_word(ACT_BYTE, 8'hFF, 24'h000000);
  endtask

  // ignored command, payload-less write, continuous read ended by abort,
  // spare action code
  task automatic test_command_corners();
    send_word(ACT_BYTE, 8'hFF, 24'h000000);   // bit 7 set: ignored
    send_word(ACT_BYTE, cmd_byte(1'b0, REG_STATUS, 1'b0), 24'h000000);
    send_word(ACT_BYTE, cmd_byte(1'b1, REG_DATA, 1'b1), 24'h000000);
    repeat (5) send_word(ACT_BYTE, 8'h00, 24'h000000);
    send_word(ACT_ABORT, 8'h00, 24'h000000);
    send_word(ACT_SPARE, 8'hFF, 24'hFFFFFF);
  endtask

  // period zero: every tick completes a conversion
  task automatic test_conversion_ticks();
    write_setting(CFG_PERIOD, 16'h0000);
    send_word(ACT_TICK, 8'h00, 24'hFFFFFF);
    send_word(ACT_TICK, 8'hFF, 24'h000000);
  endtask

  // mostly well-formed transfers with random content, mixed with ticks,
  // aborts, stray bytes and spare codes
  task automatic test_random_traffic(input logic [15:0] period, input logic [15:0] id_word,
                                     input int n_words, input bit no_idle);
    int          sent;
    int          roll;
    int          budget;
    logic [7:0]  cmd;
    write_setting(CFG_PERIOD, period);
    write_setting(CFG_DEVID, id_word);
    steady = no_idle;
    sent = 0;
    while (sent < n_words) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        cmd = 8'($urandom);
        cmd[7] = 1'b0;
        send_word(ACT_BYTE, cmd, 24'($urandom));
        sent++;
        // enough for one to three continuous rounds
        budget = $urandom_range(3, 10);
        while (!adc_await && budget > 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 10) send_word(ACT_TICK, 8'($urandom), 24'($urandom));
          else if (roll < 13) send_word(ACT_ABORT, 8'($urandom), 24'($urandom));
          else send_word(ACT_BYTE, 8'($urandom), 24'($urandom));
          budget--;
          sent++;
        end
        if (!adc_await) begin
          send_word(ACT_ABORT, 8'($urandom), 24'($urandom));
          sent++;
        end
      end else begin
        if (roll < 85) send_word(ACT_TICK, 8'($urandom), 24'($urandom));
        else if (roll < 92) send_word(ACT_ABORT, 8'($urandom), 24'($urandom));
        else if (roll < 96) send_word(ACT_BYTE, 8'($urandom), 24'($urandom));  // stray byte
        else send_word(ACT_SPARE, 8'($urandom), 24'($urandom));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_action          = ACT_BYTE;
    in_spi_in_byte     = 8'h00;
    in_conversion_data = 24'h0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_PERIOD;
    cfg_data           = 16'h0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_command_corners();
    test_conversion_ticks();
    // settings swept from zero to all ones; the all-ones phase runs without idling
    test_random_traffic(16'h0000, 16'h0000, 150, 1'b0);
    test_random_traffic(16'hFFFF, 16'hFFFF, 150, 1'b1);
    test_random_traffic(16'd3, 16'($urandom), 250, 1'b0);
    test_random_traffic(PERIOD_RST, 16'($urandom), 200, 1'b0);

    wait_quiet();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
